// ===== src/pbb_pkg.sv =====
// Shared types, constants and helpers for the point-based Bellman backup block.
// No dependencies; imported by every module of the block.
package pbb_pkg;

    localparam int MAX_STATES  = 64;
    localparam int MAX_SUCC    = 8;
    localparam int MAX_ACTIONS = 8;
    localparam int MAX_OBS     = 8;
    localparam int MAX_ALPHAS  = 64;
    localparam int BELIEF_NZ   = 8;
    localparam int QDEPTH      = 4;

    localparam int SW  = 6;   // state index
    localparam int AW  = 3;   // action index
    localparam int LW  = 3;   // successor slot
    localparam int OW  = 3;   // observation index
    localparam int JW  = 6;   // alpha index
    localparam int KW  = 3;   // belief slot
    localparam int QAW = 2;

    localparam int SUCC_DEPTH  = MAX_STATES * MAX_ACTIONS * MAX_SUCC;
    localparam int OBS_DEPTH   = MAX_ACTIONS * MAX_STATES * MAX_OBS;
    localparam int REW_DEPTH   = MAX_STATES * MAX_ACTIONS;
    localparam int ALPHA_DEPTH = MAX_ALPHAS * MAX_STATES;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [2:0] {
        REQ_SUCC   = 3'd0,
        REQ_OBS    = 3'd1,
        REQ_REW    = 3'd2,
        REQ_ALPHA  = 3'd3,
        REQ_BELIEF = 3'd4,
        REQ_START  = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        CMD_SUCC,
        CMD_OBS,
        CMD_REW,
        CMD_ALPHA,
        CMD_BELIEF,
        CMD_START
    } cmd_kind_t;

    typedef enum logic [2:0] {
        CFG_DISCOUNT   = 3'd0,
        CFG_NUM_STATES = 3'd1,
        CFG_NUM_ACT    = 3'd2,
        CFG_NUM_OBS    = 3'd3,
        CFG_NUM_ALPHAS = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [SW-1:0]      state_idx;
        logic [AW-1:0]      action_idx;
        logic [2:0]         slot_idx;
        logic [OW-1:0]      obs_idx;
        logic [JW-1:0]      alpha_idx;
        logic signed [6:0]  target_state;
        logic signed [31:0] value;
    } cmd_t;

    // Clamped loop bounds
    typedef struct packed {
        logic [15:0] discount;
        logic [6:0]  n;
        logic [3:0]  m;
        logic [3:0]  z;
        logic [6:0]  rg;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_A_CHK, ST_INIT_CHK, ST_INIT_WR, ST_O_CHK, ST_J_CHK, ST_K_CHK,
        ST_J_END, ST_KV_MUL, ST_KV_ACC, ST_U_CHK, ST_U_RD, ST_U_WR, ST_SC_CHK,
        ST_SC_MUL, ST_SC_ACC, ST_SC_CMP, ST_CP_CHK, ST_CP_WR, ST_EMIT_CHK,
        ST_EMIT_LD, ST_P_SUCC, ST_P_SUCC_W, ST_P_OBS_W, ST_P_MUL2, ST_P_ACC,
        ST_P_DISC, ST_P_DONE
    } st_t;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
        logic signed [32:0] s;
        s = {x[31], x} + {y[31], y};
        if (s[32] != s[31]) begin
            return s[32] ? VAL_MIN : VAL_MAX;
        end
        return s[31:0];
    endfunction

    // List entry is live: not negative and below the state count
    function automatic logic tgt_ok(input logic [6:0] t, input logic [6:0] n);
        return !t[6] && (t < n);
    endfunction

endpackage

// ===== src/pbb_front.sv =====
// Front end: accepts stream transactions, classifies the request and queues it.
// Depends on pbb_pkg.
module pbb_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [63:0]    s_axis_tdata,
    input  logic [2:0]     s_axis_tuser,
    output logic           q_valid,
    output pbb_pkg::cmd_t  q_cmd,
    input  logic           q_pop
);
    import pbb_pkg::*;

    cmd_t            q_mem [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]    cnt_reg, cnt_next;
    cmd_t            in_cmd;
    logic            keep;
    logic            push;

    always_comb begin
        in_cmd.kind         = CMD_START;
        in_cmd.state_idx    = s_axis_tdata[5:0];
        in_cmd.action_idx   = s_axis_tdata[8:6];
        in_cmd.slot_idx     = s_axis_tdata[11:9];
        in_cmd.obs_idx      = s_axis_tdata[14:12];
        in_cmd.alpha_idx    = s_axis_tdata[20:15];
        in_cmd.target_state = s_axis_tdata[27:21];
        in_cmd.value        = s_axis_tdata[59:28];
        keep                = 1'b1;
        unique case (s_axis_tuser)
            REQ_SUCC:   in_cmd.kind = CMD_SUCC;
            REQ_OBS:    in_cmd.kind = CMD_OBS;
            REQ_REW:    in_cmd.kind = CMD_REW;
            REQ_ALPHA:  in_cmd.kind = CMD_ALPHA;
            REQ_BELIEF: in_cmd.kind = CMD_BELIEF;
            REQ_START:  in_cmd.kind = CMD_START;
            default:    keep = 1'b0;  // unused codes: drop
        endcase
    end

    assign s_axis_tready = (cnt_reg != (QAW+1)'(QDEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign q_valid       = (cnt_reg != '0);
    assign q_cmd         = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !push) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("queue count lost a pop");

endmodule

// ===== src/pbb_back.sv =====
// Back end: executes queued loads into the tables and runs the backup sequencer,
// one shared multiplier, and the result register. Depends on pbb_pkg.
module pbb_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  pbb_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  pbb_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_state,
    output logic signed [31:0] m_value,
    output logic [2:0]         m_action,
    output logic               m_last
);
    import pbb_pkg::*;

    // Tables
    logic [22:0]        succ_mem  [SUCC_DEPTH];
    logic [15:0]        obs_mem   [OBS_DEPTH];
    logic signed [31:0] rew_mem   [REW_DEPTH];
    logic signed [31:0] alpha_mem [ALPHA_DEPTH];
    logic signed [31:0] work_mem  [MAX_STATES];
    logic signed [31:0] bvec_mem  [MAX_STATES];
    logic [6:0]         bel_st    [BELIEF_NZ];
    logic [15:0]        bel_pr    [BELIEF_NZ];

    logic [22:0]        succ_q;
    logic [15:0]        obs_q;
    logic signed [31:0] rew_q, alpha_q, work_q, bvec_q;

    st_t                st_reg, st_next;
    logic [3:0]         a_cnt_reg, o_cnt_reg, k_cnt_reg, l_cnt_reg;
    logic [6:0]         s_cnt_reg, j_cnt_reg;
    logic [SW-1:0]      ps_reg;
    logic [JW-1:0]      pj_reg, bj_reg;
    logic               ctx_reg;
    logic signed [31:0] acc_reg, val_reg, best_reg, score_reg, bscore_reg, proj_reg;
    logic [AW-1:0]      held_reg;
    logic signed [48:0] mul_reg;

    logic               out_valid_reg;
    logic [5:0]         out_state_reg;
    logic signed [31:0] out_value_reg;
    logic [2:0]         out_action_reg;
    logic               out_last_reg;

    logic               ld;
    logic               succ_re, obs_re, rew_re, work_re, work_we, bvec_re, bvec_we;
    logic [11:0]        succ_ra, obs_ra, alpha_ra;
    logic [8:0]         rew_ra;
    logic [SW-1:0]      work_ra, s_idx;
    logic signed [31:0] work_wd, mul_a, mul_hi;
    logic [15:0]        mul_b;
    logic [6:0]         sp;
    logic               sp_ok, bel_ok, s_lt_n;
    logic [6:0]         bel_k_st;
    logic [15:0]        bel_k_pr;

    assign s_idx    = s_cnt_reg[SW-1:0];
    assign sp       = succ_q[22:16];
    assign sp_ok    = tgt_ok(sp, cfg.n);
    assign bel_k_st = bel_st[k_cnt_reg[KW-1:0]];
    assign bel_k_pr = bel_pr[k_cnt_reg[KW-1:0]];
    assign bel_ok   = (k_cnt_reg < 4'(BELIEF_NZ)) && tgt_ok(bel_k_st, cfg.n);
    assign s_lt_n   = (s_cnt_reg < cfg.n);
    assign mul_hi   = mul_reg[47:16];
    assign ld       = (st_reg == ST_IDLE) && q_valid;
    assign q_pop    = ld;

    // Next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:     if (q_valid && q_cmd.kind == CMD_START) st_next = ST_A_CHK;
            ST_A_CHK:    st_next = (a_cnt_reg < cfg.m) ? ST_INIT_CHK : ST_EMIT_CHK;
            ST_INIT_CHK: st_next = s_lt_n ? ST_INIT_WR : ST_O_CHK;
            ST_INIT_WR:  st_next = ST_INIT_CHK;
            ST_O_CHK:    st_next = (o_cnt_reg < cfg.z) ? ST_J_CHK : ST_SC_CHK;
            ST_J_CHK:    st_next = (j_cnt_reg < cfg.rg) ? ST_K_CHK : ST_U_CHK;
            ST_K_CHK:    st_next = bel_ok ? ST_P_SUCC : ST_J_END;
            ST_J_END:    st_next = ST_J_CHK;
            ST_KV_MUL:   st_next = ST_KV_ACC;
            ST_KV_ACC:   st_next = ST_K_CHK;
            ST_U_CHK:    st_next = s_lt_n ? ST_P_SUCC : ST_O_CHK;
            ST_U_RD:     st_next = ST_U_WR;
            ST_U_WR:     st_next = ST_U_CHK;
            ST_SC_CHK:   st_next = bel_ok ? ST_SC_MUL : ST_SC_CMP;
            ST_SC_MUL:   st_next = ST_SC_ACC;
            ST_SC_ACC:   st_next = ST_SC_CHK;
            ST_SC_CMP:   st_next = (score_reg > bscore_reg) ? ST_CP_CHK : ST_A_CHK;
            ST_CP_CHK:   st_next = s_lt_n ? ST_CP_WR : ST_A_CHK;
            ST_CP_WR:    st_next = ST_CP_CHK;
            ST_EMIT_CHK: begin
                if (!s_lt_n) begin
                    st_next = ST_IDLE;
                end else if (!out_valid_reg || m_ready) begin
                    st_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:  st_next = ST_EMIT_CHK;
            ST_P_SUCC:   st_next = (l_cnt_reg < 4'(MAX_SUCC)) ? ST_P_SUCC_W : ST_P_DISC;
            ST_P_SUCC_W: st_next = sp_ok ? ST_P_OBS_W : ST_P_DISC;
            ST_P_OBS_W:  st_next = ST_P_MUL2;
            ST_P_MUL2:   st_next = ST_P_ACC;
            ST_P_ACC:    st_next = ST_P_SUCC;
            ST_P_DISC:   st_next = ST_P_DONE;
            ST_P_DONE:   st_next = ctx_reg ? ST_U_RD : ST_KV_MUL;
            default:     st_next = ST_IDLE;
        endcase
    end

    // Memory strobes and multiplier operands
    always_comb begin
        succ_re  = (st_reg == ST_P_SUCC) && (l_cnt_reg < 4'(MAX_SUCC));
        succ_ra  = {ps_reg, a_cnt_reg[AW-1:0], l_cnt_reg[LW-1:0]};
        obs_re   = (st_reg == ST_P_SUCC_W) && sp_ok;
        obs_ra   = {a_cnt_reg[AW-1:0], sp[SW-1:0], o_cnt_reg[OW-1:0]};
        alpha_ra = {pj_reg, sp[SW-1:0]};
        rew_re   = (st_reg == ST_INIT_CHK) && s_lt_n;
        rew_ra   = {s_idx, a_cnt_reg[AW-1:0]};
        work_re  = 1'b0;
        work_ra  = s_idx;
        work_we  = 1'b0;
        work_wd  = rew_q;
        bvec_re  = (st_reg == ST_EMIT_CHK) && (st_next == ST_EMIT_LD);
        bvec_we  = (st_reg == ST_CP_WR);
        mul_a    = '0;
        mul_b    = '0;
        unique case (st_reg)
            ST_SC_CHK: begin
                work_re = bel_ok;
                work_ra = bel_k_st[SW-1:0];
            end
            ST_U_RD, ST_CP_CHK: work_re = 1'b1;
            ST_INIT_WR: work_we = 1'b1;
            ST_U_WR: begin
                work_we = 1'b1;
                work_wd = sat_add(work_q, proj_reg);
            end
            ST_P_OBS_W: begin
                mul_a = {16'd0, obs_q};
                mul_b = succ_q[15:0];
            end
            ST_P_MUL2: begin
                mul_a = alpha_q;
                mul_b = mul_hi[15:0];
            end
            ST_P_DISC: begin
                mul_a = acc_reg;
                mul_b = cfg.discount;
            end
            ST_KV_MUL: begin
                mul_a = proj_reg;
                mul_b = bel_k_pr;
            end
            ST_SC_MUL: begin
                mul_a = work_q;
                mul_b = bel_k_pr;
            end
            default: ;
        endcase
    end

    // Tables: loads write, sequencer reads with registered data
    always_ff @(posedge aclk) begin
        if (ld && q_cmd.kind == CMD_SUCC) begin
            succ_mem[{q_cmd.state_idx, q_cmd.action_idx, q_cmd.slot_idx}] <=
                {q_cmd.target_state, q_cmd.value[15:0]};
        end
        if (succ_re) begin
            succ_q <= succ_mem[succ_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld && q_cmd.kind == CMD_OBS) begin
            obs_mem[{q_cmd.action_idx, q_cmd.state_idx, q_cmd.obs_idx}] <= q_cmd.value[15:0];
        end
        if (obs_re) begin
            obs_q <= obs_mem[obs_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld && q_cmd.kind == CMD_ALPHA) begin
            alpha_mem[{q_cmd.alpha_idx, q_cmd.state_idx}] <= q_cmd.value;
        end
        if (obs_re) begin
            alpha_q <= alpha_mem[alpha_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld && q_cmd.kind == CMD_REW) begin
            rew_mem[{q_cmd.state_idx, q_cmd.action_idx}] <= q_cmd.value;
        end
        if (rew_re) begin
            rew_q <= rew_mem[rew_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (work_we) begin
            work_mem[s_idx] <= work_wd;
        end
        if (work_re) begin
            work_q <= work_mem[work_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (bvec_we) begin
            bvec_mem[s_idx] <= work_q;
        end
        if (bvec_re) begin
            bvec_q <= bvec_mem[s_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld && q_cmd.kind == CMD_BELIEF) begin
            bel_st[q_cmd.slot_idx] <= q_cmd.target_state;
            bel_pr[q_cmd.slot_idx] <= q_cmd.value[15:0];
        end
    end

    // Shared multiplier: Q16.16 times unsigned Q0.16, product registered
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * $signed({1'b0, mul_b});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            held_reg  <= '0;
            a_cnt_reg <= '0;
            o_cnt_reg <= '0;
            j_cnt_reg <= '0;
            k_cnt_reg <= '0;
            l_cnt_reg <= '0;
            s_cnt_reg <= '0;
            ctx_reg   <= 1'b0;
        end else begin
            st_reg <= st_next;
            unique case (st_reg)
                ST_IDLE: if (q_valid && q_cmd.kind == CMD_START) begin
                    a_cnt_reg  <= '0;
                    bscore_reg <= VAL_MIN;
                end
                ST_A_CHK:    s_cnt_reg <= '0;
                ST_INIT_CHK: if (!s_lt_n) o_cnt_reg <= '0;
                ST_INIT_WR:  s_cnt_reg <= s_cnt_reg + 1'b1;
                ST_O_CHK: begin
                    if (o_cnt_reg < cfg.z) begin
                        best_reg  <= VAL_MIN;
                        bj_reg    <= '0;
                        j_cnt_reg <= '0;
                    end else begin
                        k_cnt_reg <= '0;
                        score_reg <= '0;
                    end
                end
                ST_J_CHK: begin
                    if (j_cnt_reg < cfg.rg) begin
                        val_reg   <= '0;
                        k_cnt_reg <= '0;
                    end else begin
                        s_cnt_reg <= '0;
                    end
                end
                ST_K_CHK: if (bel_ok) begin
                    ps_reg    <= bel_k_st[SW-1:0];
                    pj_reg    <= j_cnt_reg[JW-1:0];
                    ctx_reg   <= 1'b0;
                    l_cnt_reg <= '0;
                    acc_reg   <= '0;
                end
                ST_J_END: begin
                    if (val_reg > best_reg) begin
                        best_reg <= val_reg;
                        bj_reg   <= j_cnt_reg[JW-1:0];
                    end
                    j_cnt_reg <= j_cnt_reg + 1'b1;
                end
                ST_KV_ACC: begin
                    val_reg   <= sat_add(val_reg, mul_hi);
                    k_cnt_reg <= k_cnt_reg + 1'b1;
                end
                ST_U_CHK: begin
                    if (s_lt_n) begin
                        ps_reg    <= s_idx;
                        pj_reg    <= bj_reg;
                        ctx_reg   <= 1'b1;
                        l_cnt_reg <= '0;
                        acc_reg   <= '0;
                    end else begin
                        o_cnt_reg <= o_cnt_reg + 1'b1;
                    end
                end
                ST_U_WR:     s_cnt_reg <= s_cnt_reg + 1'b1;
                ST_SC_ACC: begin
                    score_reg <= sat_add(score_reg, mul_hi);
                    k_cnt_reg <= k_cnt_reg + 1'b1;
                end
                ST_SC_CMP: begin
                    if (score_reg > bscore_reg) begin
                        bscore_reg <= score_reg;
                        held_reg   <= a_cnt_reg[AW-1:0];
                        s_cnt_reg  <= '0;
                    end else begin
                        a_cnt_reg <= a_cnt_reg + 1'b1;
                    end
                end
                ST_CP_CHK:   if (!s_lt_n) a_cnt_reg <= a_cnt_reg + 1'b1;
                ST_CP_WR:    s_cnt_reg <= s_cnt_reg + 1'b1;
                ST_EMIT_LD:  s_cnt_reg <= s_cnt_reg + 1'b1;
                ST_P_ACC: begin
                    acc_reg   <= sat_add(acc_reg, mul_hi);
                    l_cnt_reg <= l_cnt_reg + 1'b1;
                end
                ST_P_DONE:   proj_reg <= mul_hi;
                default: ;
            endcase
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (st_reg == ST_EMIT_LD) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_EMIT_LD) begin
            out_state_reg  <= s_idx;
            out_value_reg  <= bvec_q;
            out_action_reg <= held_reg;
            out_last_reg   <= (s_cnt_reg == cfg.n - 7'd1);
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_state  = out_state_reg;
    assign m_value  = out_value_reg;
    assign m_action = out_action_reg;
    assign m_last   = out_last_reg;

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> ({1'b0, m_state} == cfg.n - 7'd1))
        else $error("last element flagged on wrong state");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_EMIT_LD) |-> !out_valid_reg)
        else $error("result register overwritten");
    a_succ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        l_cnt_reg <= 4'(MAX_SUCC))
        else $error("successor walk overran");
    a_belief_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        k_cnt_reg <= 4'(BELIEF_NZ))
        else $error("belief walk overran");

endmodule

// ===== src/pomdp_point_bellman_backup.sv =====
// A load is queued, then written to its table when the idle back end pops it from the queue.
// A start runs the nested walk on one shared multiplier: per action, rewards seed the work
// vector; per observation the best alpha by belief-weighted projection is added to it; the
// vector is scored on the belief and held if it beats the best score; then the held vector
// is emitted. One transaction in work at a time; the 4-entry queue accepts until it is full.
// Reset clears control and restores the config defaults; tables stay undefined until loaded.
module pomdp_point_bellman_backup (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // state_idx[5:0] action_idx[8:6] slot_idx[11:9] obs_idx[14:12]
    // alpha_idx[20:15] target_state[27:21] value[59:28], zero pad
    input  logic [63:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,    // req_type
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_state[5:0] out_value[37:6] best_action[40:38], zero pad
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,    // is_last
    // Configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import pbb_pkg::*;

    logic [15:0] discount_reg;
    logic [6:0]  num_states_reg, num_alphas_reg;
    logic [3:0]  num_actions_reg, num_obs_reg;
    cfg_t        cfg;
    logic        q_valid, q_pop;
    cmd_t        q_cmd;
    logic [5:0]  m_state;
    logic signed [31:0] m_value;
    logic [2:0]  m_action;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            discount_reg    <= 16'd62259;
            num_states_reg  <= 7'd64;
            num_actions_reg <= 4'd8;
            num_obs_reg     <= 4'd8;
            num_alphas_reg  <= 7'd1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_DISCOUNT:   discount_reg    <= cfg_wdata;
                CFG_NUM_STATES: num_states_reg  <= cfg_wdata[6:0];
                CFG_NUM_ACT:    num_actions_reg <= cfg_wdata[3:0];
                CFG_NUM_OBS:    num_obs_reg     <= cfg_wdata[3:0];
                CFG_NUM_ALPHAS: num_alphas_reg  <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Saturate counts at the table limits
    always_comb begin
        cfg.discount = discount_reg;
        cfg.n  = (num_states_reg  > 7'(MAX_STATES))  ? 7'(MAX_STATES)  : num_states_reg;
        cfg.m  = (num_actions_reg > 4'(MAX_ACTIONS)) ? 4'(MAX_ACTIONS) : num_actions_reg;
        cfg.z  = (num_obs_reg     > 4'(MAX_OBS))     ? 4'(MAX_OBS)     : num_obs_reg;
        cfg.rg = (num_alphas_reg  > 7'(MAX_ALPHAS))  ? 7'(MAX_ALPHAS)  : num_alphas_reg;
    end

    pbb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    pbb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_state  (m_state),
        .m_value  (m_value),
        .m_action (m_action),
        .m_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, m_action, m_value, m_state};

endmodule

// ===== tb/tb_pomdp_point_bellman_backup.sv =====
// Self-checking testbench for pomdp_point_bellman_backup: loads tables, runs backups and
// compares every emitted alpha element with an in-bench predictor of the backup.
// Depends on pbb_pkg (request, config index codes) and the RTL top module.
module tb_pomdp_point_bellman_backup;
    import pbb_pkg::*;

    localparam logic [2:0] REQ_SPARE6 = 3'd6;   // unused request codes, block ignores them
    localparam logic [2:0] REQ_SPARE7 = 3'd7;
    localparam int STALL_LIMIT = 8000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [2:0]         code;
        logic [5:0]         st;
        logic [2:0]         ac;
        logic [2:0]         sl;
        logic [2:0]         ob;
        logic [5:0]         al;
        logic signed [6:0]  tgt;
        logic signed [31:0] val;
    } load_item_t;

    typedef struct {
        logic [5:0]         st;
        logic signed [31:0] val;
        logic [2:0]         act;
        logic               last;
    } alpha_elem_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    pomdp_point_bellman_backup u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Backup predictor: its own copy of config, tables and held vector
    // ---------------------------------------------------------------
    logic [15:0] disc_r = 16'd62259;
    logic [6:0]  nstates_r = 7'd64;
    logic [3:0]  nact_r = 4'd8;
    logic [3:0]  nobs_r = 4'd8;
    logic [6:0]  nalpha_r = 7'd1;

    logic signed [6:0]  succ_t   [SUCC_DEPTH];
    logic [15:0]        trans_p  [SUCC_DEPTH];
    logic [15:0]        obs_p    [OBS_DEPTH];
    logic signed [31:0] rew_t    [REW_DEPTH];
    logic signed [31:0] alpha_m  [ALPHA_DEPTH];
    logic signed [6:0]  bel_st   [BELIEF_NZ];
    logic [15:0]        bel_p    [BELIEF_NZ];
    logic signed [31:0] work_v   [MAX_STATES];
    logic signed [31:0] best_v   [MAX_STATES];
    logic signed [31:0] best_sc = VAL_MIN;
    logic [2:0]         held_act = '0;

    // Written flags: the generator never lets the block read an unwritten entry
    bit succ_w [SUCC_DEPTH];
    bit obs_w  [OBS_DEPTH];
    bit rew_w  [REW_DEPTH];
    bit alpha_w[ALPHA_DEPTH];
    bit bel_w  [BELIEF_NZ];
    bit bestv_w[MAX_STATES];

    load_item_t  pend_q[$];       // items waiting for the driver
    alpha_elem_t alpha_exp_q[$];  // predicted alpha elements, oldest first

    int s_idle_pct = 0;
    int m_idle_pct = 0;
    int mismatches = 0;
    int elems_seen = 0;
    int starts_sent = 0;
    int loads_sent = 0;

    function automatic int clamp_to(input int v, input int hi);
        return v > hi ? hi : v;
    endfunction

    function automatic logic signed [31:0] sat32(input longint x);
        if (x > longint'(VAL_MAX)) return VAL_MAX;
        if (x < longint'(VAL_MIN)) return VAL_MIN;
        return x[31:0];
    endfunction

    // Q16.16 times Q0.16, floor toward minus infinity
    function automatic logic signed [31:0] mul_weight(input logic signed [31:0] v,
                                                      input logic [15:0] w);
        longint p;
        p = longint'(v) * longint'({16'd0, w});
        p = p >>> 16;
        return p[31:0];
    endfunction

    function automatic logic signed [31:0] project_alpha(input int n, input int s,
                                                         input int a, input int o,
                                                         input int j);
        logic signed [31:0] acc;
        int idx;
        int sp;
        logic [31:0] pr;
        acc = '0;
        for (int l = 0; l < MAX_SUCC; l++) begin
            idx = (s * MAX_ACTIONS + a) * MAX_SUCC + l;
            sp = int'(succ_t[idx]);
            if (sp < 0 || sp >= n) break;
            pr = ({16'd0, obs_p[(a * MAX_STATES + sp) * MAX_OBS + o]} *
                  {16'd0, trans_p[idx]}) >> 16;
            acc = sat32(longint'(acc) + longint'(mul_weight(alpha_m[j * MAX_STATES + sp],
                                                            pr[15:0])));
        end
        return mul_weight(acc, disc_r);
    endfunction

    function automatic logic signed [31:0] belief_weighted(input int n, input int a,
                                                           input int o, input int j);
        logic signed [31:0] acc;
        int bs;
        acc = '0;
        for (int k = 0; k < BELIEF_NZ; k++) begin
            bs = int'(bel_st[k]);
            if (bs < 0 || bs >= n) break;
            acc = sat32(longint'(acc) +
                        longint'(mul_weight(project_alpha(n, bs, a, o, j), bel_p[k])));
        end
        return acc;
    endfunction

    function automatic void run_backup();
        int n, m, z, rg, bj, bs;
        logic signed [31:0] best, v, score;
        n = clamp_to(int'(nstates_r), MAX_STATES);
        m = clamp_to(int'(nact_r), MAX_ACTIONS);
        z = clamp_to(int'(nobs_r), MAX_OBS);
        rg = clamp_to(int'(nalpha_r), MAX_ALPHAS);
        best_sc = VAL_MIN;
        for (int a = 0; a < m; a++) begin
            for (int s = 0; s < n; s++) work_v[s] = rew_t[s * MAX_ACTIONS + a];
            for (int o = 0; o < z; o++) begin
                best = VAL_MIN;
                bj = 0;
                for (int j = 0; j < rg; j++) begin
                    v = belief_weighted(n, a, o, j);
                    if (v > best) begin
                        best = v;
                        bj = j;
                    end
                end
                for (int s = 0; s < n; s++)
                    work_v[s] = sat32(longint'(work_v[s]) +
                                      longint'(project_alpha(n, s, a, o, bj)));
            end
            score = '0;
            for (int k = 0; k < BELIEF_NZ; k++) begin
                bs = int'(bel_st[k]);
                if (bs < 0 || bs >= n) break;
                score = sat32(longint'(score) + longint'(mul_weight(work_v[bs], bel_p[k])));
            end
            if (score > best_sc) begin
                for (int s = 0; s < n; s++) begin
                    best_v[s] = work_v[s];
                    bestv_w[s] = 1'b1;
                end
                held_act = a[2:0];
                best_sc = score;
            end
        end
    endfunction

    // Apply one load to the predictor tables and queue it for the driver
    function automatic void send_load(input logic [2:0] code, input int st, input int ac,
                                      input int sl, input int ob, input int al,
                                      input logic signed [6:0] tgt,
                                      input logic signed [31:0] val);
        load_item_t it;
        int idx;
        it.code = code;
        it.st = st[5:0];
        it.ac = ac[2:0];
        it.sl = sl[2:0];
        it.ob = ob[2:0];
        it.al = al[5:0];
        it.tgt = tgt;
        it.val = val;
        case (code)
            REQ_SUCC: begin
                idx = (it.st * MAX_ACTIONS + it.ac) * MAX_SUCC + it.sl;
                succ_t[idx] = tgt;
                trans_p[idx] = val[15:0];
                succ_w[idx] = 1'b1;
            end
            REQ_OBS: begin
                idx = (it.ac * MAX_STATES + it.st) * MAX_OBS + it.ob;
                obs_p[idx] = val[15:0];
                obs_w[idx] = 1'b1;
            end
            REQ_REW: begin
                rew_t[it.st * MAX_ACTIONS + it.ac] = val;
                rew_w[it.st * MAX_ACTIONS + it.ac] = 1'b1;
            end
            REQ_ALPHA: begin
                alpha_m[it.al * MAX_STATES + it.st] = val;
                alpha_w[it.al * MAX_STATES + it.st] = 1'b1;
            end
            REQ_BELIEF: begin
                bel_st[it.sl] = tgt;
                bel_p[it.sl] = val[15:0];
                bel_w[it.sl] = 1'b1;
            end
            default: ;
        endcase
        pend_q.push_back(it);
        loads_sent++;
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3, 4: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_prob();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0: r[15:0] = 16'hFFFF;
            1: r[15:0] = 16'h0000;
            default: ;
        endcase
        return r;
    endfunction

    // List target: end marker, live state, or a state past the count (also ends the list)
    function automatic logic signed [6:0] rand_target(input int n);
        int r;
        r = $urandom_range(5);
        if (r == 0) return -7'sd1;
        if (r == 1 && n < 64) return 7'($urandom_range(n, 63));
        if (r == 2) return 7'($urandom_range(64, 127));   // negative codes, all bits
        return n > 0 ? 7'($urandom_range(n - 1)) : -7'sd1;
    endfunction

    // Write whatever the next backup will read and that was never loaded
    function automatic void fill_reads();
        int n, m, z, rg, idx, sp, bs;
        n = clamp_to(int'(nstates_r), MAX_STATES);
        m = clamp_to(int'(nact_r), MAX_ACTIONS);
        z = clamp_to(int'(nobs_r), MAX_OBS);
        rg = clamp_to(int'(nalpha_r), MAX_ALPHAS);
        if (rg == 0) rg = 1;   // alpha 0 stands in when no alpha is in use
        for (int k = 0; k < BELIEF_NZ; k++) begin
            if (!bel_w[k])
                send_load(REQ_BELIEF, $urandom, $urandom, k, $urandom, $urandom,
                          rand_target(n), rand_prob());
            bs = int'(bel_st[k]);
            if (bs < 0 || bs >= n) break;
        end
        for (int s = 0; s < n; s++) begin
            for (int a = 0; a < m; a++) begin
                if (!rew_w[s * MAX_ACTIONS + a])
                    send_load(REQ_REW, s, a, $urandom, $urandom, $urandom, 7'($urandom),
                              rand_value());
                for (int l = 0; l < MAX_SUCC; l++) begin
                    idx = (s * MAX_ACTIONS + a) * MAX_SUCC + l;
                    if (!succ_w[idx])
                        send_load(REQ_SUCC, s, a, l, $urandom, $urandom,
                                  ($urandom_range(1) == 0) ? -7'sd1 : rand_target(n),
                                  rand_prob());
                    sp = int'(succ_t[idx]);
                    if (sp < 0 || sp >= n) break;
                    for (int o = 0; o < z; o++)
                        if (!obs_w[(a * MAX_STATES + sp) * MAX_OBS + o])
                            send_load(REQ_OBS, sp, a, $urandom, o, $urandom, 7'($urandom),
                                      rand_prob());
                    for (int j = 0; j < rg; j++)
                        if (!alpha_w[j * MAX_STATES + sp])
                            send_load(REQ_ALPHA, sp, $urandom, $urandom, $urandom, j,
                                      7'($urandom), rand_value());
                end
            end
        end
    endfunction

    // Queue a start and its predicted vector; drop it if it would re-emit an unwritten
    // part of the held vector (all actions at the most negative score)
    function automatic void send_start();
        logic signed [31:0] saved_v[MAX_STATES];
        bit saved_w[MAX_STATES];
        logic [2:0] saved_act;
        bit ok;
        int n;
        load_item_t it;
        alpha_elem_t e;
        fill_reads();
        saved_v = best_v;
        saved_w = bestv_w;
        saved_act = held_act;
        run_backup();
        n = clamp_to(int'(nstates_r), MAX_STATES);
        ok = 1'b1;
        for (int s = 0; s < n; s++) if (!bestv_w[s]) ok = 1'b0;
        if (!ok) begin
            best_v = saved_v;
            bestv_w = saved_w;
            held_act = saved_act;
            return;
        end
        it.code = REQ_START;
        it.st = 6'($urandom);
        it.ac = 3'($urandom);
        it.sl = 3'($urandom);
        it.ob = 3'($urandom);
        it.al = 6'($urandom);
        it.tgt = 7'($urandom);
        it.val = $urandom;
        pend_q.push_back(it);
        starts_sent++;
        for (int s = 0; s < n; s++) begin
            e.st = s[5:0];
            e.val = best_v[s];
            e.act = held_act;
            e.last = (s == n - 1);
            alpha_exp_q.push_back(e);
        end
    endfunction

    // Random load with every field free, unused request codes included;
    // starts come only through send_start
    function automatic void send_noise();
        logic [2:0] code;
        code = 3'($urandom_range(6));
        if (code == REQ_START) code = REQ_SPARE7;
        send_load(code, $urandom, $urandom, $urandom, $urandom, $urandom,
                  7'($urandom), ($urandom_range(1) == 0) ? rand_value() : rand_prob());
    endfunction

    // ---------------------------------------------------------------
    // Driver: presents queued transactions, changes inputs on the falling edge
    // ---------------------------------------------------------------
    logic s_fire = 1'b0;
    load_item_t drv_item;

    always @(posedge aclk) begin
        s_fire <= s_axis_tvalid && s_axis_tready;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            // Advance only when nothing is held or the held transaction just went in
            if (!s_axis_tvalid || s_fire) begin
                if (pend_q.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                    drv_item = pend_q.pop_front();
                    s_axis_tdata <= {4'd0, drv_item.val, drv_item.tgt, drv_item.al,
                                     drv_item.ob, drv_item.sl, drv_item.ac, drv_item.st};
                    s_axis_tuser <= drv_item.code;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compares each result transaction with the oldest prediction
    // ---------------------------------------------------------------
    alpha_elem_t mon_exp;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s differs: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            elems_seen++;
            if (alpha_exp_q.size() == 0) begin
                report_mismatch("unexpected element, state", -1, m_axis_tdata[5:0]);
            end else begin
                mon_exp = alpha_exp_q.pop_front();
                if (m_axis_tdata[5:0] != mon_exp.st)
                    report_mismatch("out_state", mon_exp.st, m_axis_tdata[5:0]);
                if ($signed(m_axis_tdata[37:6]) != mon_exp.val)
                    report_mismatch("out_value", mon_exp.val, $signed(m_axis_tdata[37:6]));
                if (m_axis_tdata[40:38] != mon_exp.act)
                    report_mismatch("best_action", mon_exp.act, m_axis_tdata[40:38]);
                if (m_axis_tlast != mon_exp.last)
                    report_mismatch("is_last", mon_exp.last, m_axis_tlast);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d items pending, %0d elements outstanding",
                     pend_q.size(), alpha_exp_q.size());
            $display("pomdp_point_bellman_backup: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DISCOUNT:   disc_r = v;
            CFG_NUM_STATES: nstates_r = v[6:0];
            CFG_NUM_ACT:    nact_r = v[3:0];
            CFG_NUM_OBS:    nobs_r = v[3:0];
            CFG_NUM_ALPHAS: nalpha_r = v[6:0];
            default: ;
        endcase
    endtask

    // Hold until every queued transaction went in and every element came out,
    // then let a start that yields nothing run out
    task automatic drain();
        wait (pend_q.size() == 0 && alpha_exp_q.size() == 0 && !s_axis_tvalid);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_shape(input int ns, input int na, input int no, input int nal,
                             input int dsc);
        write_reg(CFG_DISCOUNT, dsc[15:0]);
        write_reg(CFG_NUM_STATES, ns[15:0]);
        write_reg(CFG_NUM_ACT, na[15:0]);
        write_reg(CFG_NUM_OBS, no[15:0]);
        write_reg(CFG_NUM_ALPHAS, nal[15:0]);
    endtask

    initial begin
        int ns, na, no, nal, dsc, pick;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: tiny shape, full discount, then the special cases
        set_shape(2, 2, 1, 1, 65535);
        send_start();
        drain();
        // Every action ties at the most negative score: the held vector comes out again
        for (int s = 0; s < 2; s++)
            for (int a = 0; a < 2; a++)
                send_load(REQ_REW, s, a, 0, 0, 0, 0, VAL_MIN);
        send_load(REQ_BELIEF, 0, 0, 0, 0, 0, 7'sd0, 32'h0000_FFFF);
        send_load(REQ_BELIEF, 0, 0, 1, 0, 0, 7'sd0, 32'hFFFF_FFFF);
        send_load(REQ_BELIEF, 0, 0, 2, 0, 0, -7'sd1, 32'd0);
        send_load(REQ_SPARE6, 63, 7, 7, 7, 63, -7'sd64, VAL_MAX);
        send_load(REQ_SPARE7, 0, 0, 0, 0, 0, 7'sd63, VAL_MIN);
        send_start();
        // Belief list ended by a state past the count
        send_load(REQ_BELIEF, 0, 0, 0, 0, 0, 7'sd1, 32'h0000_8000);
        send_load(REQ_BELIEF, 0, 0, 1, 0, 0, 7'sd2, 32'h0000_8000);
        send_start();
        drain();
        // No states: start gives nothing
        write_reg(CFG_NUM_STATES, 16'd0);
        send_start();
        drain();
        // No actions: held vector again, zero discount, alpha count zero
        set_shape(2, 0, 1, 0, 0);
        send_start();
        drain();
        // Counts above their limits saturate; single-action wide shape
        set_shape(127, 1, 1, 1, 32768);
        send_start();
        drain();
        set_shape(1, 15, 15, 127, 65535);
        send_start();
        drain();

        // Random phases: receiver-heavy idle, sender-heavy idle, then none
        for (int b = 0; b < 24; b++) begin
            s_idle_pct = (b < 8) ? 33 : (b < 16) ? 87 : 0;
            m_idle_pct = (b < 8) ? 87 : (b < 16) ? 33 : 0;
            if (b % 3 == 0) begin
                pick = $urandom_range(9);
                ns = $urandom_range(1, 5);
                na = $urandom_range(1, 3);
                no = $urandom_range(1, 3);
                nal = $urandom_range(1, 4);
                if (pick == 0) begin
                    ns = ($urandom_range(1) == 0) ? 64 : $urandom_range(9, 40);
                    na = 1;
                    no = 1;
                    nal = 1;
                end else if (pick == 1) begin
                    ns = $urandom_range(1, 3);
                    na = 1;
                    no = $urandom_range(1, 2);
                    nal = $urandom_range(40, 64);
                end else if (pick == 2) begin
                    ns = 1;
                end
                case ($urandom_range(3))
                    0: dsc = 0;
                    1: dsc = 65535;
                    default: dsc = $urandom_range(65535);
                endcase
                set_shape(ns, na, no, nal, dsc);
            end
            repeat ($urandom_range(1, 3)) send_noise();
            if ($urandom_range(3) != 0) send_start();
            drain();
        end

        $display("covered %0d load and %0d start transactions, %0d alpha elements checked",
                 loads_sent, starts_sent, elems_seen);
        $display("shapes from zero to saturated counts, three idle patterns on both sides");
        if (mismatches == 0 && alpha_exp_q.size() == 0)
            $display("pomdp_point_bellman_backup: match");
        else
            $display("pomdp_point_bellman_backup: mismatch");
        $finish;
    end

endmodule
